/* rtl/lkr_pkg.sv */
package lkr_pkg;

	localparam int FRAMES_DEF     = 64;
	localparam int STAMP_BITS_DEF = 32;
	localparam int COUNT_BITS_DEF = 8;

	localparam logic [7:0] K_RESET   = 8'd2;
	localparam logic [6:0] FIU_RESET = 7'd64;

	// request modes
	localparam logic [1:0] OP_ACCESS = 2'd0;
	localparam logic [1:0] OP_SETEV  = 2'd1;
	localparam logic [1:0] OP_REMOVE = 2'd2;
	localparam logic [1:0] OP_EVICT  = 2'd3;

	// result status
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_BAD_ID  = 2'd1;
	localparam logic [1:0] ST_PINNED  = 2'd2;
	localparam logic [1:0] ST_EMPTY   = 2'd3;

	// configuration register indexes
	localparam logic REG_K      = 1'b0;
	localparam logic REG_FRAMES = 1'b1;

	typedef struct packed {
		logic       act;
		logic [1:0] op;
	} cmd_t;

	typedef struct packed {
		logic trk;
		logic ev;
	} sel_t;

endpackage

/* rtl/lkr_cell.sv */
module lkr_cell #(
	parameter int FRAMES     = lkr_pkg::FRAMES_DEF,
	parameter int STAMP_BITS = lkr_pkg::STAMP_BITS_DEF,
	parameter int COUNT_BITS = lkr_pkg::COUNT_BITS_DEF,
	parameter int IDX        = 0,
	localparam int IW        = $clog2(FRAMES)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  lkr_pkg::cmd_t         cmd,
	input  logic [IW-1:0]         cmd_id,
	input  logic                  cmd_ev,
	input  logic [COUNT_BITS-1:0] k_eff,
	input  logic [STAMP_BITS-1:0] now,
	input  logic                  tok_in_valid,
	input  logic                  tok_in_cache,
	input  logic [STAMP_BITS-1:0] tok_in_stamp,
	input  logic [IW-1:0]         tok_in_idx,
	output logic                  tok_out_valid,
	output logic                  tok_out_cache,
	output logic [STAMP_BITS-1:0] tok_out_stamp,
	output logic [IW-1:0]         tok_out_idx,
	output lkr_pkg::sel_t         sel
);

	logic                  trk_q;
	logic                  ev_q;
	logic [COUNT_BITS-1:0] hits_q;
	logic [STAMP_BITS-1:0] stamp_q;

	logic                  hit_me;
	logic                  cache;
	logic                  qual;
	logic                  better;
	logic [COUNT_BITS-1:0] hits_inc;

	assign hit_me   = cmd.act && (cmd_id == IW'(IDX));
	assign cache    = (hits_q >= k_eff);
	assign qual     = trk_q && ev_q;
	assign better   = qual && (!tok_in_valid ||
		({cache, stamp_q} < {tok_in_cache, tok_in_stamp}));
	assign hits_inc = (hits_q < k_eff) ? hits_q + 1'b1 : hits_q;

	assign sel.trk = (cmd_id == IW'(IDX)) && trk_q;
	assign sel.ev  = (cmd_id == IW'(IDX)) && ev_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trk_q <= 1'b0;
			ev_q  <= 1'b0;
		end else if (hit_me) begin
			unique case (cmd.op)
				lkr_pkg::OP_ACCESS: begin
					if (!trk_q) begin
						trk_q <= 1'b1;
						ev_q  <= 1'b0;
					end
				end
				lkr_pkg::OP_SETEV: begin
					if (trk_q) begin
						ev_q <= cmd_ev;
					end
				end
				lkr_pkg::OP_REMOVE, lkr_pkg::OP_EVICT: begin
					trk_q <= 1'b0;
					ev_q  <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (hit_me && cmd.op == lkr_pkg::OP_ACCESS) begin
			if (!trk_q) begin
				hits_q  <= COUNT_BITS'(1);
				stamp_q <= now;
			end else begin
				hits_q <= hits_inc;
				if (hits_inc >= k_eff) begin
					stamp_q <= now;
				end
			end
		end
	end

	// search token moves one cell per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_out_valid <= 1'b0;
		end else begin
			tok_out_valid <= tok_in_valid || qual;
		end
	end

	always_ff @(posedge clk) begin
		if (better) begin
			tok_out_cache <= cache;
			tok_out_stamp <= stamp_q;
			tok_out_idx   <= IW'(IDX);
		end else begin
			tok_out_cache <= tok_in_cache;
			tok_out_stamp <= tok_in_stamp;
			tok_out_idx   <= tok_in_idx;
		end
	end

endmodule

/* rtl/lkr_ctrl.sv */
module lkr_ctrl #(
	parameter int FRAMES     = lkr_pkg::FRAMES_DEF,
	parameter int STAMP_BITS = lkr_pkg::STAMP_BITS_DEF,
	parameter int COUNT_BITS = lkr_pkg::COUNT_BITS_DEF,
	localparam int IW        = $clog2(FRAMES)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [1:0]            mode,
	input  logic [5:0]            frame_idx,
	input  logic                  evictable_value,
	output logic                  done,
	output logic [1:0]            status,
	output logic                  victim_valid,
	output logic [5:0]            victim_frame,
	output logic [6:0]            evictable_count,
	input  logic                  cfg_we,
	input  logic                  cfg_index,
	input  logic [7:0]            cfg_wdata,
	output lkr_pkg::cmd_t         cmd,
	output logic [IW-1:0]         cmd_id,
	output logic                  cmd_ev,
	output logic [COUNT_BITS-1:0] k_eff,
	output logic [STAMP_BITS-1:0] now,
	input  lkr_pkg::sel_t         sel,
	input  logic                  tok_valid,
	input  logic [IW-1:0]         tok_idx
);

	localparam int LW = (IW + 1 > 7) ? IW + 1 : 7;
	localparam int TW = (LW > 7) ? LW : 7;
	localparam int KW = (COUNT_BITS > 8) ? COUNT_BITS : 8;
	localparam int CW = (IW > 0) ? IW : 1;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_EXEC = 2'd2;

	logic [1:0]            state_q;
	logic [CW-1:0]         scan_q;
	logic [1:0]            mode_q;
	logic [5:0]            id_q;
	logic                  ev_q;
	logic [7:0]            k_q;
	logic [6:0]            fiu_q;
	logic [STAMP_BITS-1:0] clock_q;
	logic [TW-1:0]         total_q;
	logic                  done_q;
	logic [1:0]            status_q;
	logic                  vv_q;
	logic [5:0]            vf_q;

	logic [KW-1:0]         kx;
	logic [KW-1:0]         hmax;
	logic [LW-1:0]         lim;
	logic [LW-1:0]         id_x;
	logic [LW-1:0]         vic_x;
	logic                  id_ok;
	logic                  accept;

	logic [1:0]            st_d;
	logic                  vv_d;
	logic [TW-1:0]         total_d;
	logic                  clk_inc;

	assign accept = start && (state_q == S_IDLE);
	assign busy   = (state_q != S_IDLE);

	assign kx    = KW'(k_q);
	assign hmax  = KW'({COUNT_BITS{1'b1}});
	assign k_eff = (kx == '0) ? COUNT_BITS'(1) :
		(kx > hmax) ? hmax[COUNT_BITS-1:0] : kx[COUNT_BITS-1:0];

	assign lim   = (LW'(fiu_q) > LW'(FRAMES)) ? LW'(FRAMES) : LW'(fiu_q);
	assign id_x  = LW'(id_q);
	assign id_ok = (id_x < lim);
	assign vic_x = LW'(tok_idx);
	assign now   = clock_q;
	assign cmd_ev = ev_q;

	always_comb begin
		cmd.act = 1'b0;
		cmd.op  = mode_q;
		cmd_id  = id_x[IW-1:0];
		st_d    = lkr_pkg::ST_OK;
		vv_d    = 1'b0;
		total_d = total_q;
		clk_inc = 1'b0;
		if (state_q == S_EXEC) begin
			if (mode_q == lkr_pkg::OP_EVICT) begin
				cmd_id = tok_idx;
				if (tok_valid) begin
					cmd.act = 1'b1;
					vv_d    = 1'b1;
					total_d = total_q - 1'b1;
				end else begin
					st_d = lkr_pkg::ST_EMPTY;
				end
			end else if (!id_ok) begin
				st_d = lkr_pkg::ST_BAD_ID;
			end else begin
				unique case (mode_q)
					lkr_pkg::OP_ACCESS: begin
						cmd.act = 1'b1;
						clk_inc = (clock_q != '1);
					end
					lkr_pkg::OP_SETEV: begin
						cmd.act = 1'b1;
						if (sel.trk && ev_q && !sel.ev) begin
							total_d = total_q + 1'b1;
						end else if (sel.trk && !ev_q && sel.ev) begin
							total_d = total_q - 1'b1;
						end
					end
					lkr_pkg::OP_REMOVE: begin
						if (sel.trk && !sel.ev) begin
							st_d = lkr_pkg::ST_PINNED;
						end else if (sel.trk) begin
							cmd.act = 1'b1;
							total_d = total_q - 1'b1;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			scan_q  <= '0;
			k_q     <= lkr_pkg::K_RESET;
			fiu_q   <= lkr_pkg::FIU_RESET;
			clock_q <= '0;
			total_q <= '0;
			done_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					lkr_pkg::REG_K:      k_q   <= cfg_wdata;
					lkr_pkg::REG_FRAMES: fiu_q <= cfg_wdata[6:0];
					default: begin
					end
				endcase
			end
			done_q <= (state_q == S_EXEC);
			unique case (state_q)
				S_IDLE: begin
					scan_q <= '0;
					if (accept) begin
						state_q <= (mode == lkr_pkg::OP_EVICT) ? S_SCAN : S_EXEC;
					end
				end
				S_SCAN: begin
					scan_q <= scan_q + 1'b1;
					if (scan_q == CW'(FRAMES - 1)) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= S_IDLE;
					total_q <= total_d;
					if (clk_inc) begin
						clock_q <= clock_q + 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= mode;
			id_q   <= frame_idx;
			ev_q   <= evictable_value;
		end
		if (state_q == S_EXEC) begin
			status_q <= st_d;
			vv_q     <= vv_d;
			vf_q     <= vv_d ? vic_x[5:0] : 6'd0;
		end
	end

	assign done            = done_q;
	assign status          = status_q;
	assign victim_valid    = vv_q;
	assign victim_frame    = vf_q;
	assign evictable_count = total_q[6:0];

endmodule

/* rtl/lru_k_frame_replacer.sv */
// LRU-K frame replacer. A request is taken when start is high and busy is low.
// Record access, set evictable and remove go from idle straight to the execute
// state; evict first waits in a scan state while the search token walks the
// row of frame cells one cell per cycle. The result is on the outputs for exactly
// one cycle with done high and cannot be held off: capture it on that cycle.
// A new request may be issued in the cycle that done is high.
module lru_k_frame_replacer #(
	parameter int FRAMES     = lkr_pkg::FRAMES_DEF,
	parameter int STAMP_BITS = lkr_pkg::STAMP_BITS_DEF,
	parameter int COUNT_BITS = lkr_pkg::COUNT_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [1:0] mode,
	input  logic [5:0] frame_idx,
	input  logic       evictable_value,
	output logic       done,
	output logic [1:0] status,
	output logic       victim_valid,
	output logic [5:0] victim_frame,
	output logic [6:0] evictable_count,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [7:0] cfg_wdata
);

	localparam int IW = $clog2(FRAMES);

	lkr_pkg::cmd_t         cmd;
	logic [IW-1:0]         cmd_id;
	logic                  cmd_ev;
	logic [COUNT_BITS-1:0] k_eff;
	logic [STAMP_BITS-1:0] now;
	lkr_pkg::sel_t         sel;
	lkr_pkg::sel_t         sel_arr [FRAMES];
	logic [FRAMES-1:0]     trk_vec;
	logic [FRAMES-1:0]     ev_vec;

	logic                  tok_v [FRAMES+1];
	logic                  tok_c [FRAMES+1];
	logic [STAMP_BITS-1:0] tok_s [FRAMES+1];
	logic [IW-1:0]         tok_i [FRAMES+1];

	assign tok_v[0] = 1'b0;
	assign tok_c[0] = 1'b0;
	assign tok_s[0] = '0;
	assign tok_i[0] = '0;

	for (genvar i = 0; i < FRAMES; i++) begin : g_cell
		lkr_cell #(
			.FRAMES     (FRAMES),
			.STAMP_BITS (STAMP_BITS),
			.COUNT_BITS (COUNT_BITS),
			.IDX        (i)
		) u_cell (
			.clk           (clk),
			.arst_n        (arst_n),
			.cmd           (cmd),
			.cmd_id        (cmd_id),
			.cmd_ev        (cmd_ev),
			.k_eff         (k_eff),
			.now           (now),
			.tok_in_valid  (tok_v[i]),
			.tok_in_cache  (tok_c[i]),
			.tok_in_stamp  (tok_s[i]),
			.tok_in_idx    (tok_i[i]),
			.tok_out_valid (tok_v[i+1]),
			.tok_out_cache (tok_c[i+1]),
			.tok_out_stamp (tok_s[i+1]),
			.tok_out_idx   (tok_i[i+1]),
			.sel           (sel_arr[i])
		);
		assign trk_vec[i] = sel_arr[i].trk;
		assign ev_vec[i]  = sel_arr[i].ev;
	end

	assign sel.trk = |trk_vec;
	assign sel.ev  = |ev_vec;

	lkr_ctrl #(
		.FRAMES     (FRAMES),
		.STAMP_BITS (STAMP_BITS),
		.COUNT_BITS (COUNT_BITS)
	) u_ctrl (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.mode            (mode),
		.frame_idx       (frame_idx),
		.evictable_value (evictable_value),
		.done            (done),
		.status          (status),
		.victim_valid    (victim_valid),
		.victim_frame    (victim_frame),
		.evictable_count (evictable_count),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_wdata       (cfg_wdata),
		.cmd             (cmd),
		.cmd_id          (cmd_id),
		.cmd_ev          (cmd_ev),
		.k_eff           (k_eff),
		.now             (now),
		.sel             (sel),
		.tok_valid       (tok_v[FRAMES]),
		.tok_idx         (tok_i[FRAMES])
	);

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps

module testbench;

	localparam int NFR = 64;
	localparam int STALL_LIMIT = 2000;

	typedef struct packed {
		logic [1:0] status;
		logic       victim_valid;
		logic [5:0] victim_frame;
		logic [6:0] evictable_count;
	} reply_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       start = 1'b0;
	logic [1:0] mode = lkr_pkg::OP_ACCESS;
	logic [5:0] frame_idx = '0;
	logic       evictable_value = 1'b0;
	logic       cfg_we = 1'b0;
	logic       cfg_index = lkr_pkg::REG_K;
	logic [7:0] cfg_wdata = '0;
	logic       busy;
	logic       done;
	logic [1:0] status;
	logic       victim_valid;
	logic [5:0] victim_frame;
	logic [6:0] evictable_count;

	lru_k_frame_replacer uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.mode(mode),
		.frame_idx(frame_idx),
		.evictable_value(evictable_value),
		.done(done),
		.status(status),
		.victim_valid(victim_valid),
		.victim_frame(victim_frame),
		.evictable_count(evictable_count),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always #2 clk = ~clk;

	// replacer state mirror
	logic        tracked [NFR];
	logic        evict_ok [NFR];
	logic [7:0]  hit_cnt [NFR];
	logic [31:0] stamp [NFR];
	logic [31:0] access_clk;
	int          ev_total;
	logic [7:0]  k_reg;
	logic [6:0]  fiu_reg;

	reply_t pending_replies[$];
	int     mismatches = 0;
	int     stall_cycles = 0;
	bit     idle_on = 1'b1;

	function automatic void clear_frame(int i);
		tracked[i] = 1'b0;
		evict_ok[i] = 1'b0;
		hit_cnt[i] = '0;
		stamp[i] = '0;
	endfunction

	function automatic void reset_mirror();
		for (int i = 0; i < NFR; i++)
			clear_frame(i);
		access_clk = '0;
		ev_total = 0;
		k_reg = lkr_pkg::K_RESET;
		fiu_reg = lkr_pkg::FIU_RESET;
	endfunction

	function automatic int oldest_frame(logic cache_class, logic [7:0] k_eff);
		int best;
		best = -1;
		for (int i = 0; i < NFR; i++) begin
			if (!tracked[i] || !evict_ok[i])
				continue;
			if ((hit_cnt[i] >= k_eff) != cache_class)
				continue;
			if (best < 0 || stamp[i] < stamp[best])
				best = i;
		end
		return best;
	endfunction

	function automatic reply_t apply_request(logic [1:0] m, logic [5:0] id, logic ev);
		reply_t r;
		logic [7:0] k_eff;
		logic [6:0] lim;
		int v;
		r = '0;
		k_eff = (k_reg == 8'd0) ? 8'd1 : k_reg;
		lim = (fiu_reg > 7'd64) ? 7'd64 : fiu_reg;
		if (m == lkr_pkg::OP_EVICT) begin
			v = oldest_frame(1'b0, k_eff);
			if (v < 0)
				v = oldest_frame(1'b1, k_eff);
			if (v < 0) begin
				r.status = lkr_pkg::ST_EMPTY;
			end else begin
				clear_frame(v);
				ev_total--;
				r.victim_valid = 1'b1;
				r.victim_frame = v[5:0];
			end
		end else if ({1'b0, id} >= lim) begin
			r.status = lkr_pkg::ST_BAD_ID;
		end else if (m == lkr_pkg::OP_ACCESS) begin
			if (!tracked[id]) begin
				tracked[id] = 1'b1;
				evict_ok[id] = 1'b0;
				hit_cnt[id] = 8'd1;
				stamp[id] = access_clk;
			end else begin
				if (hit_cnt[id] < k_eff)
					hit_cnt[id]++;
				if (hit_cnt[id] >= k_eff)
					stamp[id] = access_clk;
			end
			if (access_clk != '1)
				access_clk++;
		end else if (m == lkr_pkg::OP_SETEV) begin
			if (tracked[id]) begin
				if (ev && !evict_ok[id])
					ev_total++;
				else if (!ev && evict_ok[id])
					ev_total--;
				evict_ok[id] = ev;
			end
		end else begin
			if (tracked[id]) begin
				if (!evict_ok[id]) begin
					r.status = lkr_pkg::ST_PINNED;
				end else begin
					clear_frame(id);
					ev_total--;
				end
			end
		end
		r.evictable_count = ev_total[6:0];
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		if (!idle_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	// call at a rising edge; returns at the edge that takes the request
	task automatic send_request(logic [1:0] m, logic [5:0] id, logic ev);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		mode <= m;
		frame_idx <= id;
		evictable_value <= ev;
		do @(posedge clk); while (busy);
		pending_replies.push_back(apply_request(m, id, ev));
	endtask

	task automatic drain();
		start <= 1'b0;
		while (pending_replies.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [7:0] val);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == lkr_pkg::REG_K)
			k_reg = val;
		else
			fiu_reg = val[6:0];
	endtask

	task automatic report(string what, int exp_v, int act_v);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch %s: expected %0d got %0d", what, exp_v, act_v);
	endtask

	always @(posedge clk) begin
		reply_t exp_r;
		if (arst_n && done) begin
			if (pending_replies.size() == 0) begin
				report("unexpected result, status", -1, status);
			end else begin
				exp_r = pending_replies.pop_front();
				if (status !== exp_r.status)
					report("status", exp_r.status, status);
				if (victim_valid !== exp_r.victim_valid)
					report("victim_valid", exp_r.victim_valid, victim_valid);
				if (victim_frame !== exp_r.victim_frame)
					report("victim_frame", exp_r.victim_frame, victim_frame);
				if (evictable_count !== exp_r.evictable_count)
					report("evictable_count", exp_r.evictable_count, evictable_count);
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done || cfg_we)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic test_basic_ops();
		send_request(lkr_pkg::OP_EVICT, 6'd0, 1'b0);
		send_request(lkr_pkg::OP_ACCESS, 6'd0, 1'b0);
		send_request(lkr_pkg::OP_ACCESS, 6'd63, 1'b1);
		send_request(lkr_pkg::OP_REMOVE, 6'd0, 1'b0);
		send_request(lkr_pkg::OP_REMOVE, 6'd5, 1'b0);
		send_request(lkr_pkg::OP_SETEV, 6'd5, 1'b1);
		send_request(lkr_pkg::OP_SETEV, 6'd0, 1'b1);
		send_request(lkr_pkg::OP_SETEV, 6'd63, 1'b1);
		send_request(lkr_pkg::OP_SETEV, 6'd63, 1'b0);
		send_request(lkr_pkg::OP_SETEV, 6'd63, 1'b1);
		send_request(lkr_pkg::OP_ACCESS, 6'd63, 1'b0);
		send_request(lkr_pkg::OP_EVICT, 6'd0, 1'b0);
		send_request(lkr_pkg::OP_EVICT, 6'd0, 1'b0);
	endtask

	task automatic test_id_bounds();
		write_reg(lkr_pkg::REG_FRAMES, 8'd10);
		send_request(lkr_pkg::OP_ACCESS, 6'd10, 1'b0);
		send_request(lkr_pkg::OP_SETEV, 6'd42, 1'b1);
		send_request(lkr_pkg::OP_ACCESS, 6'd9, 1'b0);
		send_request(lkr_pkg::OP_SETEV, 6'd9, 1'b1);
		write_reg(lkr_pkg::REG_FRAMES, 8'd1);
		send_request(lkr_pkg::OP_EVICT, 6'd21, 1'b0);
		write_reg(lkr_pkg::REG_FRAMES, 8'd0);
		send_request(lkr_pkg::OP_ACCESS, 6'd0, 1'b0);
		write_reg(lkr_pkg::REG_FRAMES, 8'd127);
		send_request(lkr_pkg::OP_ACCESS, 6'd63, 1'b0);
		send_request(lkr_pkg::OP_REMOVE, 6'd63, 1'b0);
	endtask

	task automatic test_k_extremes();
		write_reg(lkr_pkg::REG_K, 8'd0);
		send_request(lkr_pkg::OP_ACCESS, 6'd20, 1'b0);
		send_request(lkr_pkg::OP_SETEV, 6'd20, 1'b1);
		send_request(lkr_pkg::OP_EVICT, 6'd0, 1'b0);
		write_reg(lkr_pkg::REG_K, 8'd255);
		send_request(lkr_pkg::OP_ACCESS, 6'd22, 1'b0);
		send_request(lkr_pkg::OP_ACCESS, 6'd22, 1'b0);
		send_request(lkr_pkg::OP_SETEV, 6'd22, 1'b1);
		send_request(lkr_pkg::OP_EVICT, 6'd0, 1'b0);
	endtask

	// fill every frame, make all evictable, then empty the pool by eviction
	task automatic test_full_pool();
		write_reg(lkr_pkg::REG_K, 8'd2);
		write_reg(lkr_pkg::REG_FRAMES, 8'd64);
		idle_on = 1'b1;
		for (int i = 0; i < NFR; i++) begin
			send_request(lkr_pkg::OP_ACCESS, i[5:0], 1'b0);
			if ($urandom_range(0, 3) == 0)
				send_request(lkr_pkg::OP_ACCESS, i[5:0], 1'b0);
		end
		for (int i = 0; i < NFR; i++)
			send_request(lkr_pkg::OP_SETEV, 6'(NFR - 1 - i), 1'b1);
		for (int i = 0; i <= NFR; i++)
			send_request(lkr_pkg::OP_EVICT, 6'($urandom_range(0, 63)), 1'b0);
	endtask

	task automatic test_random_mix();
		logic [7:0] k_set [7];
		logic [6:0] fiu_set [7];
		int hot_max, r;
		logic [1:0] m;
		logic [5:0] id;
		logic ev;
		k_set = '{8'd2, 8'd1, 8'd3, 8'd255, 8'd4, 8'($urandom_range(1, 6)), 8'd2};
		fiu_set = '{7'd64, 7'd64, 7'd16, 7'd64, 7'd1, 7'($urandom_range(1, 64)), 7'd40};
		for (int ph = 0; ph < 7; ph++) begin
			write_reg(lkr_pkg::REG_K, k_set[ph]);
			write_reg(lkr_pkg::REG_FRAMES, {1'b0, fiu_set[ph]});
			idle_on = (ph % 3 != 2);
			hot_max = (fiu_set[ph] > 12) ? 11 : fiu_set[ph] - 1;
			for (int n = 0; n < 170; n++) begin
				r = $urandom_range(0, 99);
				if (r < 40)
					m = lkr_pkg::OP_ACCESS;
				else if (r < 65)
					m = lkr_pkg::OP_SETEV;
				else if (r < 75)
					m = lkr_pkg::OP_REMOVE;
				else
					m = lkr_pkg::OP_EVICT;
				ev = ($urandom_range(0, 99) < 75);
				if ($urandom_range(0, 99) < 5)
					id = 6'($urandom_range(0, 63));
				else if ($urandom_range(0, 99) < 70)
					id = 6'($urandom_range(0, hot_max));
				else
					id = 6'($urandom_range(0, fiu_set[ph] - 1));
				send_request(m, id, ev);
			end
		end
	endtask

	initial begin
		reset_mirror();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_basic_ops();
		test_id_bounds();
		test_k_extremes();
		test_full_pool();
		test_random_mix();
		drain();
		repeat (80) @(posedge clk);
		if (mismatches == 0 && pending_replies.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
